@@ hw/rtl/slk_pkg.sv @@
package slk_pkg;

    // operation codes of an input item
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RX_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TX_MESSAGES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TX_LENGTH   = 2'd3;

    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd900;
    localparam logic [15:0] MAX_RX_LENGTH_RST   = 16'd2000;
    localparam logic [11:0] MAX_TX_MESSAGES_RST = 12'd1000;
    localparam logic [11:0] MAX_TX_LENGTH_RST   = 12'd2000;

    // saturation point of the queued message count
    localparam logic [11:0] MSG_COUNT_MAX = 12'd4095;

    // message terminator
    localparam logic [7:0] TERM_BYTE = 8'h00;

    // classified item between front and back
    typedef struct packed {
        logic       is_push;
        logic [7:0] push_byte;
        logic       push_term;
        logic       ack_seen;
        logic       peer_strobe;
        logic [7:0] peer_byte;
        logic       peer_term;
    } item_t;

    // one result item
    typedef struct packed {
        logic       push_accepted;
        logic       tx_strobe;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
    } result_t;

endpackage

@@ hw/rtl/slk_front.sv @@
module slk_front
(
    input  logic           operation,
    input  logic [7:0]     push_byte,
    input  logic           ack_seen,
    input  logic           peer_strobe,
    input  logic [7:0]     peer_byte,
    output slk_pkg::item_t item
);

    // fields that mean nothing for the operation are cleared
    always_comb
    begin
        item = '0;
        if (operation == slk_pkg::OP_PUSH)
        begin
            item.is_push   = 1'b1;
            item.push_byte = push_byte;
            item.push_term = (push_byte == slk_pkg::TERM_BYTE);
        end
        else
        begin
            item.ack_seen    = ack_seen;
            item.peer_strobe = peer_strobe;
            item.peer_byte   = peer_byte;
            item.peer_term   = (peer_byte == slk_pkg::TERM_BYTE);
        end
    end

endmodule

@@ hw/rtl/slk_queue.sv @@
module slk_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  slk_pkg::item_t push_item,
    output logic           full,
    output logic           head_valid,
    input  logic           pop,
    output slk_pkg::item_t head_item
);

    slk_pkg::item_t slot_reg [2];
    logic           wr_sel_reg;
    logic           wr_sel_next;
    logic           rd_sel_reg;
    logic           rd_sel_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_sel_reg];

    always_comb
    begin
        wr_sel_next = push ? ~wr_sel_reg : wr_sel_reg;
        rd_sel_next = pop ? ~rd_sel_reg : rd_sel_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_sel_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/slk_back.sv @@
module slk_back
#(
    parameter int FIFO_DEPTH = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [slk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slk_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    input  slk_pkg::item_t                  item,
    output logic                            item_pop,
    output logic                            res_valid,
    input  logic                            res_stall,
    output slk_pkg::result_t                res
);

    localparam int AW     = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > 13) ? FILL_W : 13;

    // configuration
    logic [15:0] timeout_ticks_reg;
    logic [15:0] max_rx_length_reg;
    logic [11:0] max_tx_messages_reg;
    logic [11:0] max_tx_length_reg;

    // link state
    logic [AW-1:0]     rd_ptr_reg,    rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg,    wr_ptr_next;
    logic [FILL_W-1:0] fill_reg,      fill_next;
    logic [11:0]       queued_reg,    queued_next;
    logic              dropping_reg,  dropping_next;
    logic              in_msg_reg,    in_msg_next;
    logic              active_reg,    active_next;
    logic [15:0]       wait_reg,      wait_next;
    logic [15:0]       rx_count_reg,  rx_count_next;
    logic [AW-1:0]     msg_start_reg, msg_start_next;
    logic [11:0]       msg_len_reg,   msg_len_next;

    // send buffer with registered read of the head entry
    logic [7:0]  mem [FIFO_DEPTH];
    logic [7:0]  mem_rd_reg;
    logic        byp_hit_reg;
    logic [7:0]  byp_data_reg;
    logic        mem_we;
    logic [7:0]  head_byte;

    logic              out_valid_reg;
    slk_pkg::result_t  res_reg;
    slk_pkg::result_t  res_next;

    logic              fire;
    logic [AW-1:0]     rd_inc;
    logic [AW-1:0]     wr_inc;
    logic [FILL_W-1:0] room;
    logic              no_room;
    logic              too_many;
    logic [AW-1:0]     cur_start;
    logic [11:0]       cur_len;
    logic              start_ok;
    logic              proceed;
    logic              act;

    assign fire      = item_valid && (!out_valid_reg || !res_stall);
    assign item_pop  = fire;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;
    assign head_byte = byp_hit_reg ? byp_data_reg : mem_rd_reg;

    assign rd_inc   = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_inc   = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign room     = FILL_W'(FIFO_DEPTH) - fill_reg;
    assign no_room  = CMP_W'(room) < (CMP_W'(max_tx_length_reg) + CMP_W'(1));
    assign too_many = queued_reg >= max_tx_messages_reg;

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        queued_next    = queued_reg;
        dropping_next  = dropping_reg;
        in_msg_next    = in_msg_reg;
        active_next    = active_reg;
        wait_next      = wait_reg;
        rx_count_next  = rx_count_reg;
        msg_start_next = msg_start_reg;
        msg_len_next   = msg_len_reg;
        mem_we         = 1'b0;
        res_next       = '0;
        cur_start      = in_msg_reg ? msg_start_reg : wr_ptr_reg;
        cur_len        = in_msg_reg ? msg_len_reg : 12'd0;
        start_ok       = 1'b0;
        proceed        = 1'b1;
        act            = active_reg;

        if (fire && item.is_push)
        begin
            if (dropping_reg)
            begin
                if (item.push_term)
                begin
                    dropping_next = 1'b0;
                end
            end
            else if (!in_msg_reg && (too_many || no_room))
            begin
                // whole message refused at its first byte
                if (!item.push_term)
                begin
                    dropping_next = 1'b1;
                end
            end
            else
            begin
                start_ok = 1'b1;
            end

            if (start_ok)
            begin
                if ((fill_reg == FILL_W'(FIFO_DEPTH)) ||
                    (!item.push_term && (cur_len >= max_tx_length_reg)))
                begin
                    // oversize: roll back the partly stored message
                    wr_ptr_next  = cur_start;
                    fill_next    = fill_reg - FILL_W'(cur_len);
                    msg_len_next = 12'd0;
                    in_msg_next  = 1'b0;
                    if (!item.push_term)
                    begin
                        dropping_next = 1'b1;
                    end
                end
                else
                begin
                    mem_we                 = 1'b1;
                    wr_ptr_next            = wr_inc;
                    fill_next              = fill_reg + 1'b1;
                    msg_start_next         = cur_start;
                    res_next.push_accepted = 1'b1;
                    if (item.push_term)
                    begin
                        in_msg_next = 1'b0;
                        if (queued_reg < slk_pkg::MSG_COUNT_MAX)
                        begin
                            queued_next = queued_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        in_msg_next  = 1'b1;
                        msg_len_next = cur_len + 1'b1;
                    end
                end
            end
        end
        else if (fire)
        begin
            // transmit side
            if (wait_reg != 16'd0)
            begin
                if (item.ack_seen)
                begin
                    wait_next = 16'd0;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                    proceed   = 1'b0;
                end
            end

            if (proceed)
            begin
                if (!act && (queued_reg != 12'd0))
                begin
                    queued_next = queued_reg - 1'b1;
                    act         = 1'b1;
                end
                if (act && (fill_reg == '0))
                begin
                    act = 1'b0;
                end
                if (act)
                begin
                    rd_ptr_next        = rd_inc;
                    fill_next          = fill_reg - 1'b1;
                    res_next.tx_strobe = 1'b1;
                    res_next.tx_byte   = head_byte;
                    wait_next          = timeout_ticks_reg;
                    if (head_byte == slk_pkg::TERM_BYTE)
                    begin
                        act = 1'b0;
                    end
                end
                active_next = act;
            end

            // receive side
            if (item.peer_strobe)
            begin
                res_next.ack_out = 1'b1;
                if (!item.peer_term)
                begin
                    if (rx_count_reg < max_rx_length_reg)
                    begin
                        res_next.rx_valid = 1'b1;
                        res_next.rx_byte  = item.peer_byte;
                        rx_count_next     = rx_count_reg + 1'b1;
                    end
                end
                else
                begin
                    res_next.rx_last = 1'b1;
                    rx_count_next    = 16'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg   <= slk_pkg::TIMEOUT_TICKS_RST;
            max_rx_length_reg   <= slk_pkg::MAX_RX_LENGTH_RST;
            max_tx_messages_reg <= slk_pkg::MAX_TX_MESSAGES_RST;
            max_tx_length_reg   <= slk_pkg::MAX_TX_LENGTH_RST;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                slk_pkg::CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data;
                slk_pkg::CFG_MAX_RX_LENGTH:   max_rx_length_reg   <= cfg_data;
                slk_pkg::CFG_MAX_TX_MESSAGES: max_tx_messages_reg <= cfg_data[11:0];
                slk_pkg::CFG_MAX_TX_LENGTH:   max_tx_length_reg   <= cfg_data[11:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            queued_reg    <= '0;
            dropping_reg  <= 1'b0;
            in_msg_reg    <= 1'b0;
            active_reg    <= 1'b0;
            wait_reg      <= '0;
            rx_count_reg  <= '0;
            msg_start_reg <= '0;
            msg_len_reg   <= '0;
            out_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            queued_reg    <= queued_next;
            dropping_reg  <= dropping_next;
            in_msg_reg    <= in_msg_next;
            active_reg    <= active_next;
            wait_reg      <= wait_next;
            rx_count_reg  <= rx_count_next;
            msg_start_reg <= msg_start_next;
            msg_len_reg   <= msg_len_next;
            byp_hit_reg   <= mem_we && (wr_ptr_reg == rd_ptr_next);
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
        byp_data_reg <= item.push_byte;
    end

    // head entry is re-read every cycle at the next read pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= item.push_byte;
        end
        mem_rd_reg <= mem[rd_ptr_next];
    end

endmodule

@@ hw/rtl/strobe_ack_byte_message_link_core.sv @@
// strobe/ack parallel byte link carrying zero-terminated messages
//
// input channel (in_valid / in_stall): one item per handshake, either a push
//   of an outgoing message byte or one tick of the link with the peer's ack,
//   strobe and byte for that tick
// output channel (out_valid / out_stall): exactly one result item per input
//   item, in order: push_accepted for a push; tx strobe/byte, ack_out and
//   the received byte or terminator for a tick
// config port: cfg_write_enable with cfg_index and cfg_data; the user must
//   write it only while the link is idle, the block does not enforce this
//
// throughput: one item per cycle while out_stall is low; each item does one
//   send buffer access and a fixed amount of counter work in the back end,
//   and the buffer head byte is kept pre-read in a register so a tick sends
//   without a read bubble
// path: an item goes through the two-entry queue, then the result register
// reset: all counters and pointers clear, the link is idle, config returns
//   to its defaults; the send buffer is not cleared and needs no sweep
// receiver stall: the result register holds, the queue fills within two
//   items and in_stall rises; nothing is lost or repeated
module strobe_ack_byte_message_link_core
#(
    parameter int FIFO_DEPTH = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration
    input  logic                            cfg_write_enable,
    input  logic [slk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slk_pkg::CFG_DATA_W-1:0]  cfg_data,

    // input items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [7:0]                      push_byte,
    input  logic                            ack_seen,
    input  logic                            peer_strobe,
    input  logic [7:0]                      peer_byte,

    // result items
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            push_accepted,
    output logic                            tx_strobe,
    output logic [7:0]                      tx_byte,
    output logic                            ack_out,
    output logic                            rx_valid,
    output logic [7:0]                      rx_byte,
    output logic                            rx_last
);

    slk_pkg::item_t    front_item;
    slk_pkg::item_t    head_item;
    slk_pkg::result_t  res;
    logic              q_full;
    logic              q_push;
    logic              q_head_valid;
    logic              q_pop;

    // an item is taken whenever the queue has a free slot
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // front end: classify the item
    slk_front u_front
    (
        .operation   (operation),
        .push_byte   (push_byte),
        .ack_seen    (ack_seen),
        .peer_strobe (peer_strobe),
        .peer_byte   (peer_byte),
        .item        (front_item)
    );

    // short queue decoupling front and back
    slk_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (front_item),
        .full       (q_full),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .head_item  (head_item)
    );

    // back end: send buffer, transmitter, receiver, result register
    slk_back
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (q_head_valid),
        .item             (head_item),
        .item_pop         (q_pop),
        .res_valid        (out_valid),
        .res_stall        (out_stall),
        .res              (res)
    );

    assign push_accepted = res.push_accepted;
    assign tx_strobe     = res.tx_strobe;
    assign tx_byte       = res.tx_byte;
    assign ack_out       = res.ack_out;
    assign rx_valid      = res.rx_valid;
    assign rx_byte       = res.rx_byte;
    assign rx_last       = res.rx_last;

endmodule

@@ tb/strobe_ack_byte_message_link_core_test.sv @@
module strobe_ack_byte_message_link_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUF_DEPTH    = 4096;
    localparam int          DRAIN_CYCLES = 8;        // margin past the item queue and result register
    localparam int unsigned CYCLE_LIMIT  = 200000;   // watchdog limit on simulated cycles

    // one input item as the sender sees it
    typedef struct {
        logic       op;
        logic [7:0] push_val;
        logic       ack;
        logic       strobe;
        logic [7:0] peer_val;
    } link_item_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // every block input starts at a known value
    logic                           cfg_write_enable = 1'b0;
    logic [slk_pkg::CFG_IDX_W-1:0]  cfg_index = slk_pkg::CFG_TIMEOUT_TICKS;
    logic [slk_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           operation = slk_pkg::OP_TICK;
    logic [7:0]                     push_byte = 8'h00;
    logic                           ack_seen = 1'b0;
    logic                           peer_strobe = 1'b0;
    logic [7:0]                     peer_byte = 8'h00;
    logic                           out_stall = 1'b0;

    logic                           in_stall;
    logic                           out_valid;
    logic                           push_accepted;
    logic                           tx_strobe;
    logic [7:0]                     tx_byte;
    logic                           ack_out;
    logic                           rx_valid;
    logic [7:0]                     rx_byte;
    logic                           rx_last;

    strobe_ack_byte_message_link_core #(.FIFO_DEPTH(BUF_DEPTH)) i_dut (.*);

    always #5 clk = ~clk;

    // stimulus bookkeeping
    link_item_t        pending_items[$];
    link_item_t        cur_item;
    slk_pkg::result_t  expected_results[$];
    int unsigned       items_total = 0;
    int unsigned       items_accepted = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       phase_count = 0;

    // checking
    int unsigned       mismatches = 0;
    int unsigned       results_checked = 0;
    int unsigned       cycle_count = 0;
    slk_pkg::result_t  got;
    slk_pkg::result_t  want;

    // link model: its own copy of the send buffer, pointers and counters
    logic [7:0]  send_buf[BUF_DEPTH];
    int unsigned rd_ptr = 0;
    int unsigned wr_ptr = 0;
    int unsigned buf_fill = 0;
    int unsigned msgs_queued = 0;
    int unsigned msg_start = 0;
    int unsigned msg_len = 0;
    int unsigned wait_left = 0;
    int unsigned rx_kept = 0;
    bit          dropping_msg = 1'b0;
    bit          in_message = 1'b0;
    bit          sending = 1'b0;

    // register copies, starting at their reset values
    int unsigned timeout_limit = 32'(slk_pkg::TIMEOUT_TICKS_RST);
    int unsigned rx_len_limit  = 32'(slk_pkg::MAX_RX_LENGTH_RST);
    int unsigned tx_msg_limit  = 32'(slk_pkg::MAX_TX_MESSAGES_RST);
    int unsigned tx_len_limit  = 32'(slk_pkg::MAX_TX_LENGTH_RST);

    // coverage tallies for the summary
    int unsigned bytes_sent = 0;
    int unsigned bytes_kept = 0;
    int unsigned pushes_dropped = 0;
    int unsigned terminators_seen = 0;

    // a pushed byte goes into the send buffer or the message is dropped
    function automatic bit buffer_push(input logic [7:0] b);
        if (dropping_msg)
        begin
            // swallow the rest of a rejected message up to its terminator
            if (b == slk_pkg::TERM_BYTE)
                dropping_msg = 1'b0;
            return 1'b0;
        end
        if (!in_message)
        begin
            // first byte decides: message count limit or not enough room
            if (msgs_queued >= tx_msg_limit ||
                (BUF_DEPTH - buf_fill) < tx_len_limit + 1)
            begin
                if (b != slk_pkg::TERM_BYTE)
                    dropping_msg = 1'b1;
                return 1'b0;
            end
            in_message = 1'b1;
            msg_start = wr_ptr;
            msg_len = 0;
        end
        if (buf_fill >= BUF_DEPTH || (b != slk_pkg::TERM_BYTE && msg_len >= tx_len_limit))
        begin
            // oversize: take the partial message back out
            wr_ptr = msg_start;
            buf_fill -= msg_len;
            msg_len = 0;
            in_message = 1'b0;
            if (b != slk_pkg::TERM_BYTE)
                dropping_msg = 1'b1;
            return 1'b0;
        end
        send_buf[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % BUF_DEPTH;
        buf_fill++;
        if (b == slk_pkg::TERM_BYTE)
        begin
            in_message = 1'b0;
            if (msgs_queued < 32'(slk_pkg::MSG_COUNT_MAX))
                msgs_queued++;
        end
        else
            msg_len++;
        return 1'b1;
    endfunction

    // expected result of one accepted item, appended to expected_results
    function automatic void predict_link(input link_item_t it);
        slk_pkg::result_t r;
        bit               proceed;
        logic [7:0]       b;
        r = '0;
        if (it.op == slk_pkg::OP_PUSH)
        begin
            r.push_accepted = buffer_push(it.push_val);
            if (!r.push_accepted)
                pushes_dropped++;
        end
        else
        begin
            // transmitter: wait out the ack window unless the peer acks
            proceed = 1'b1;
            if (wait_left > 0)
            begin
                wait_left--;
                if (it.ack)
                    wait_left = 0;
                else
                    proceed = 1'b0;
            end
            if (proceed)
            begin
                if (!sending && msgs_queued > 0)
                begin
                    msgs_queued--;
                    sending = 1'b1;
                end
                if (sending && buf_fill == 0)
                    sending = 1'b0;
                if (sending)
                begin
                    b = send_buf[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % BUF_DEPTH;
                    buf_fill--;
                    r.tx_strobe = 1'b1;
                    r.tx_byte = b;
                    wait_left = timeout_limit;
                    bytes_sent++;
                    if (b == slk_pkg::TERM_BYTE)
                        sending = 1'b0;
                end
            end
            // receiver: ack every strobe, keep bytes up to the length limit
            if (it.strobe)
            begin
                r.ack_out = 1'b1;
                if (it.peer_val != slk_pkg::TERM_BYTE)
                begin
                    if (rx_kept < rx_len_limit)
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = it.peer_val;
                        rx_kept++;
                        bytes_kept++;
                    end
                end
                else
                begin
                    r.rx_last = 1'b1;
                    rx_kept = 0;
                    terminators_seen++;
                end
            end
        end
        expected_results.push_back(r);
    endfunction

    function automatic string show_result(input slk_pkg::result_t r);
        return $sformatf("acc=%0b txs=%0b txb=%02h ack=%0b rxv=%0b rxb=%02h last=%0b",
                         r.push_accepted, r.tx_strobe, r.tx_byte, r.ack_out,
                         r.rx_valid, r.rx_byte, r.rx_last);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // driver: present queued items, hold while stalled, idle at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_link(cur_item);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= cur_item.op;
                    push_byte   <= cur_item.push_val;
                    ack_seen    <= cur_item.ack;
                    peer_strobe <= cur_item.strobe;
                    peer_byte   <= cur_item.peer_val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {push_accepted, tx_strobe, tx_byte, ack_out, rx_valid, rx_byte, rx_last};
                if (expected_results.size() == 0)
                    note_mismatch($sformatf("unexpected result %s", show_result(got)));
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got !== want)
                        note_mismatch($sformatf("expected %s, got %s",
                                                show_result(want), show_result(got)));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // item builders; fields that mean nothing for the operation stay random
    task automatic queue_push(input logic [7:0] b);
        link_item_t it;
        it.op = slk_pkg::OP_PUSH;
        it.push_val = b;
        it.ack = 1'($urandom_range(1));
        it.strobe = 1'($urandom_range(1));
        it.peer_val = 8'($urandom_range(255));
        pending_items.push_back(it);
        items_total++;
    endtask

    task automatic queue_tick(input logic ack, input logic strobe, input logic [7:0] peer);
        link_item_t it;
        it.op = slk_pkg::OP_TICK;
        it.push_val = 8'($urandom_range(255));
        it.ack = ack;
        it.strobe = strobe;
        it.peer_val = peer;
        pending_items.push_back(it);
        items_total++;
    endtask

    // mostly whole messages and acked ticks, some stray bytes that break messages
    task automatic queue_traffic(input int unsigned count);
        int unsigned added;
        int unsigned pick;
        int unsigned len;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // well-formed message, now and then longer than the length limit
                len = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
                repeat (len)
                    queue_push(8'($urandom_range(1, 255)));
                queue_push(slk_pkg::TERM_BYTE);
                added += len + 1;
            end
            else if (pick < 38)
            begin
                // stray byte: may open, extend or end a message
                queue_push(($urandom_range(2) == 0) ? slk_pkg::TERM_BYTE
                                                    : 8'($urandom_range(255)));
                added++;
            end
            else
            begin
                // link tick: peer acks most of the time, terminators end rx messages
                queue_tick($urandom_range(99) < 75, 1'($urandom_range(1)),
                           ($urandom_range(3) == 0) ? slk_pkg::TERM_BYTE
                                                    : 8'($urandom_range(1, 255)));
                added++;
            end
        end
    endtask

    // wait until every item is in and every result is out, then a margin
    task automatic wait_drained();
        while (items_accepted != items_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all four registers while the link is quiet
    task automatic write_registers(input int unsigned t_ticks, input int unsigned rx_len,
                                   input int unsigned tx_msgs, input int unsigned tx_len);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= slk_pkg::CFG_TIMEOUT_TICKS;
        cfg_data <= 16'(t_ticks);
        @(posedge clk);
        cfg_index <= slk_pkg::CFG_MAX_RX_LENGTH;
        cfg_data <= 16'(rx_len);
        @(posedge clk);
        cfg_index <= slk_pkg::CFG_MAX_TX_MESSAGES;
        cfg_data <= 16'(tx_msgs);
        @(posedge clk);
        cfg_index <= slk_pkg::CFG_MAX_TX_LENGTH;
        cfg_data <= 16'(tx_len);
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
        timeout_limit = t_ticks & 32'hFFFF;
        rx_len_limit  = rx_len & 32'hFFFF;
        tx_msg_limit  = tx_msgs & 32'hFFF;
        tx_len_limit  = tx_len & 32'hFFF;
    endtask

    // one random phase: new settings, new idling mix, then drain
    task automatic run_phase(input int unsigned idle_p, input int unsigned stall_p,
                             input int unsigned t_ticks, input int unsigned rx_len,
                             input int unsigned tx_msgs, input int unsigned tx_len);
        write_registers(t_ticks, rx_len, tx_msgs, tx_len);
        send_idle_pct = idle_p;
        stall_pct = stall_p;
        queue_traffic(140);
        // the sender holds off here until every result is back
        wait_drained();
        phase_count++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: ack ignored while idle, send/wait/ack cycle, empty message
        queue_tick(1'b1, 1'b1, 8'hFF);
        queue_tick(1'b0, 1'b1, slk_pkg::TERM_BYTE);
        queue_push(8'hFF);
        queue_push(8'h01);
        queue_push(slk_pkg::TERM_BYTE);
        queue_tick(1'b0, 1'b0, 8'h00);     // first byte goes out, ack window opens
        queue_tick(1'b0, 1'b1, 8'h80);     // no ack: still waiting
        queue_tick(1'b1, 1'b0, 8'h00);     // ack: next byte
        queue_tick(1'b1, 1'b1, slk_pkg::TERM_BYTE);
        queue_push(slk_pkg::TERM_BYTE);    // message with no payload
        queue_tick(1'b1, 1'b0, 8'h00);
        wait_drained();

        // zero timeout, one rx byte, one queued message, longest tx message
        write_registers(0, 1, 1, 4095);
        queue_push(8'h80);
        queue_push(slk_pkg::TERM_BYTE);
        queue_push(8'h7F);                 // message count reached: dropped whole
        queue_push(slk_pkg::TERM_BYTE);
        queue_tick(1'b0, 1'b1, 8'h7E);
        queue_tick(1'b0, 1'b1, 8'h01);     // rx length exceeded: acked, not kept
        queue_push(8'h55);
        queue_push(slk_pkg::TERM_BYTE);
        queue_push(8'hAA);                 // not enough room left: dropped whole
        queue_push(slk_pkg::TERM_BYTE);
        queue_tick(1'b0, 1'b1, slk_pkg::TERM_BYTE);
        queue_tick(1'b0, 1'b0, 8'h00);
        wait_drained();

        // longest timeout and rx length, most messages, tx messages of at most one byte
        write_registers(65535, 65535, 4095, 1);
        queue_push(8'h01);
        queue_push(8'h02);                 // over the length limit: partial message removed
        queue_push(8'h03);
        queue_push(slk_pkg::TERM_BYTE);
        wait_drained();

        // random phases across settings and idling mixes
        run_phase(0, 0, 0, 3, 4095, 8);
        run_phase(59, 0, 3, 65535, 2, 5);
        run_phase(0, 59, 1, 1, 1, 1);
        run_phase(33, 33, 65535, 2000, 1000, 2000);
        run_phase(0, 0, 2, 4, 3, 12);

        if (expected_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d items over %0d random phases, %0d results checked",
                 items_total, phase_count, results_checked);
        $display("link sent %0d bytes, kept %0d rx bytes, saw %0d rx ends, dropped %0d pushes",
                 bytes_sent, bytes_kept, terminators_seen, pushes_dropped);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
